/* design/stbpi_pkg.sv */
// ----------------------------------------------------------------------------
// stbpi_pkg
// Shared types and constants for the station-time boundary point test.
// ----------------------------------------------------------------------------
package stbpi_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int MIN_POINTS     = 2;

    localparam int IDX_W   = 6;
    localparam int TIME_W  = 16;
    localparam int STA_W   = 24;
    localparam int COUNT_W = 7;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic        [TIME_W-1:0] time_ms;
        logic signed [STA_W-1:0]  lower_s;
        logic signed [STA_W-1:0]  upper_s;
    } t_entry;

endpackage

/* design/stbpi_ram.sv */
// ----------------------------------------------------------------------------
// stbpi_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module stbpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* design/stbpi_cross.sv */
// ----------------------------------------------------------------------------
// stbpi_cross
// Segment cross products against the bracketing pair and opposite-sign test.
// ----------------------------------------------------------------------------
module stbpi_cross
    import stbpi_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  t_entry                   i_left,
    input  t_entry                   i_right,
    input  logic        [TIME_W-1:0] i_qt,
    input  logic signed [STA_W-1:0]  i_qs,
    output logic                     o_vld,
    output logic                     o_inside
);

    localparam int DS_W = STA_W + 1;
    localparam int DT_W = TIME_W + 1;
    localparam int PR_W = DS_W + DT_W;

    logic signed [DS_W-1:0] ul_d, ur_d, ll_d, lr_d;
    logic signed [DT_W-1:0] tl_d, tr_d;
    logic signed [PR_W-1:0] r_pu_a, r_pu_b, r_pl_a, r_pl_b;
    logic signed [PR_W:0]   cu, cl;
    logic                   r_vld;

    always_comb begin
        ul_d = DS_W'(i_left.upper_s)  - DS_W'(i_qs);
        ur_d = DS_W'(i_right.upper_s) - DS_W'(i_qs);
        ll_d = DS_W'(i_left.lower_s)  - DS_W'(i_qs);
        lr_d = DS_W'(i_right.lower_s) - DS_W'(i_qs);
        tl_d = $signed({1'b0, i_left.time_ms})  - $signed({1'b0, i_qt});
        tr_d = $signed({1'b0, i_right.time_ms}) - $signed({1'b0, i_qt});
    end

    always_ff @(posedge i_clk) begin
        r_pu_a <= ul_d * tr_d;
        r_pu_b <= tl_d * ur_d;
        r_pl_a <= ll_d * tr_d;
        r_pl_b <= tl_d * lr_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_comb begin
        cu       = (PR_W+1)'(r_pu_a) - (PR_W+1)'(r_pu_b);
        cl       = (PR_W+1)'(r_pl_a) - (PR_W+1)'(r_pl_b);
        o_inside = ((cu > 0) && (cl < 0)) || ((cu < 0) && (cl > 0));
        o_vld    = r_vld;
    end

endmodule

/* design/st_boundary_point_inside_test_top.sv */
// ----------------------------------------------------------------------------
// st_boundary_point_inside_test_top
// Point-inside test against a station-time boundary held in RAM.
//
//  channel  | direction | handshake                         | payload
//  ---------+-----------+-----------------------------------+----------------------
//  command  | in        | i_start, o_busy                   | action, index, time, s
//  result   | out       | o_done (one-cycle strobe)         | inside, outside window
//  config   | in        | i_cfg_valid, o_cfg_ready          | i_cfg_point_count
//
//  A load returns nothing and leaves o_busy low. A query whose time lies
//  outside the window ends after the window check; otherwise it runs a binary
//  search over the table and then the cross-product test on the bracketing pair;
//  each search step is one RAM read and compare. o_done follows the last busy
//  cycle. Reset is synchronous and clears control state only; table entries
//  are undefined until loaded. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module st_boundary_point_inside_test_top
    import stbpi_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic                      i_action,
    input  logic        [IDX_W-1:0]   i_entry_index,
    input  logic        [TIME_W-1:0]  i_point_time,
    input  logic signed [STA_W-1:0]   i_lower_s,
    input  logic signed [STA_W-1:0]   i_upper_s,
    input  logic signed [STA_W-1:0]   i_query_s,
    output logic                      o_done,
    output logic                      o_inside_res,
    output logic                      o_outside_time_window,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic        [COUNT_W-1:0] i_cfg_point_count
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_CROSS,
        S_WAIT
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_lo, n_lo, r_hi, n_hi;
    logic [AW-1:0]           r_mid, n_mid;
    logic [TIME_W-1:0]       r_qt;
    logic signed [STA_W-1:0] r_qs;
    logic                    r_done, n_done;
    logic                    r_inside, n_inside;
    logic                    r_outside, n_outside;

    logic          accept, load_we, cross_vld, cross_inside, cross_go, below;
    logic [31:0]   idx_ext;
    logic [CW-1:0] s_lo, s_hi, last_idx;
    logic [AW-1:0] raddr_a, raddr_b;
    t_entry        wdata, rdata_a, rdata_b;

    assign accept   = i_start && !o_busy;
    assign idx_ext  = 32'(i_entry_index);
    assign load_we  = accept && (i_action == ACT_LOAD) && (idx_ext < 32'(MAX_POINTS));
    assign last_idx = r_count - CW'(1);
    assign wdata    = '{time_ms: i_point_time, lower_s: i_lower_s, upper_s: i_upper_s};

    stbpi_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (load_we),
        .i_waddr   (idx_ext[AW-1:0]),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .o_rdata_a (rdata_a),
        .i_raddr_b (raddr_b),
        .o_rdata_b (rdata_b)
    );

    stbpi_cross u_cross (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (cross_go),
        .i_left   (rdata_a),
        .i_right  (rdata_b),
        .i_qt     (r_qt),
        .i_qs     (r_qs),
        .o_vld    (cross_vld),
        .o_inside (cross_inside)
    );

    always_comb begin
        n_state   = r_state;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_done    = 1'b0;
        n_inside  = 1'b0;
        n_outside = 1'b0;
        cross_go  = 1'b0;
        raddr_a   = '0;
        raddr_b   = AW'(last_idx);
        below     = rdata_a.time_ms < r_qt;
        s_lo      = below ? (CW'(r_mid) + CW'(1)) : r_lo;
        s_hi      = below ? r_hi : CW'(r_mid);

        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_action == ACT_QUERY)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if ((r_qt <= rdata_a.time_ms) || (r_qt >= rdata_b.time_ms)) begin
                    n_done    = 1'b1;
                    n_outside = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_mid   = AW'(r_count >> 1);
                    raddr_a = AW'(r_count >> 1);
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                n_lo = s_lo;
                n_hi = s_hi;
                if (s_lo < s_hi) begin
                    n_mid   = AW'(({1'b0, s_lo} + {1'b0, s_hi}) >> 1);
                    raddr_a = AW'(({1'b0, s_lo} + {1'b0, s_hi}) >> 1);
                end else begin
                    priority if (s_lo == '0) begin
                        raddr_a = '0;
                        raddr_b = '0;
                    end else if (s_lo >= r_count) begin
                        raddr_a = AW'(last_idx);
                        raddr_b = AW'(last_idx);
                    end else begin
                        raddr_a = AW'(s_lo - CW'(1));
                        raddr_b = AW'(s_lo);
                    end
                    n_state = S_CROSS;
                end
            end
            S_CROSS: begin
                cross_go = 1'b1;
                n_state  = S_WAIT;
            end
            S_WAIT: begin
                if (cross_vld) begin
                    n_done   = 1'b1;
                    n_inside = cross_inside;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_inside  <= 1'b0;
            r_outside <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_done    <= n_done;
            r_inside  <= n_inside;
            r_outside <= n_outside;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        if (accept) begin
            r_qt <= i_point_time;
            r_qs <= i_query_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(MIN_POINTS);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_point_count < COUNT_W'(MIN_POINTS)) begin
                r_count <= CW'(MIN_POINTS);
            end else if (32'(i_cfg_point_count) > 32'(MAX_POINTS)) begin
                r_count <= CW'(MAX_POINTS);
            end else begin
                r_count <= CW'(i_cfg_point_count);
            end
        end
    end

    assign o_busy                = (r_state != S_IDLE);
    assign o_cfg_ready           = !o_busy;
    assign o_done                = r_done;
    assign o_inside_res          = r_inside;
    assign o_outside_time_window = r_outside;

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_action == ACT_QUERY)) |=> o_busy)
        else $error("query transaction did not make the block busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("result strobe without a query in progress");

    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> ((r_lo < r_hi) && (r_hi <= r_count)))
        else $error("binary search bounds out of order");

    a_outside_not_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_outside_time_window |-> (o_done && !o_inside_res))
        else $error("window flag with inside result or without strobe");

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for st_boundary_point_inside_test_top. Loads boundary
// tables through the command port, sweeps the point count register and fires
// query transactions in random bursts. A scoreboard keeps its own copy of the
// tables and predicts each verdict for comparison against o_done strobes.
// ----------------------------------------------------------------------------
module tb;
    import stbpi_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE      = 20;
    localparam int ITEM_GOAL   = 1050;

    typedef struct {
        logic                     action;
        logic        [IDX_W-1:0]  idx;
        logic        [TIME_W-1:0] t_ms;
        logic signed [STA_W-1:0]  lo_s;
        logic signed [STA_W-1:0]  up_s;
        logic signed [STA_W-1:0]  q_s;
    } t_cmd;

    typedef struct {
        logic inside_res;
        logic outside_win;
    } t_verdict;

    class t_boundary_scoreboard;
        logic        [TIME_W-1:0] time_tab  [MAX_POINTS_DEF];
        logic signed [STA_W-1:0]  lower_tab [MAX_POINTS_DEF];
        logic signed [STA_W-1:0]  upper_tab [MAX_POINTS_DEF];
        int                       n_used;
        t_verdict                 pending_verdicts [$];
        int                       errors;

        function new();
            n_used = MIN_POINTS;
            errors = 0;
        endfunction

        function void set_count(logic [COUNT_W-1:0] v);
            if (v < MIN_POINTS)
                n_used = MIN_POINTS;
            else if (v > MAX_POINTS_DEF)
                n_used = MAX_POINTS_DEF;
            else
                n_used = v;
        endfunction

        function int cross_sign(longint qs, longint qt, longint as, longint at,
                                longint bs, longint bt);
            longint c;
            c = (as - qs) * (bt - qt) - (at - qt) * (bs - qs);
            return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
        endfunction

        function t_verdict judge_point(logic [TIME_W-1:0] tq, logic signed [STA_W-1:0] qs);
            t_verdict v;
            int lo, hi, mid, left, right, su, sl;
            longint qt, lt, rt;
            v.inside_res  = 1'b0;
            v.outside_win = 1'b0;
            if (tq <= time_tab[0] || tq >= time_tab[n_used-1]) begin
                v.outside_win = 1'b1;
                return v;
            end
            lo = 0;
            hi = n_used;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (time_tab[mid] < tq)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo == 0) begin
                left  = 0;
                right = 0;
            end else if (lo >= n_used) begin
                left  = n_used - 1;
                right = n_used - 1;
            end else begin
                left  = lo - 1;
                right = lo;
            end
            qt = longint'(tq);
            lt = longint'(time_tab[left]);
            rt = longint'(time_tab[right]);
            su = cross_sign(longint'(qs), qt, longint'(upper_tab[left]), lt,
                            longint'(upper_tab[right]), rt);
            sl = cross_sign(longint'(qs), qt, longint'(lower_tab[left]), lt,
                            longint'(lower_tab[right]), rt);
            v.inside_res = (su * sl < 0);
            return v;
        endfunction

        function void record_command(t_cmd c);
            if (c.action == ACT_LOAD) begin
                time_tab[c.idx]  = c.t_ms;
                lower_tab[c.idx] = c.lo_s;
                upper_tab[c.idx] = c.up_s;
            end else begin
                pending_verdicts.push_back(judge_point(c.t_ms, c.q_s));
            end
        endfunction

        function void compare_verdict(logic got_inside, logic got_outside);
            t_verdict e;
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: inside_res=%0b outside_time_window=%0b",
                       got_inside, got_outside);
                errors++;
                return;
            end
            e = pending_verdicts.pop_front();
            if (got_inside !== e.inside_res) begin
                $error("inside_res: expected %0b, actual %0b", e.inside_res, got_inside);
                errors++;
            end
            if (got_outside !== e.outside_win) begin
                $error("outside_time_window: expected %0b, actual %0b",
                       e.outside_win, got_outside);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_start;
    logic                      o_busy;
    logic                      i_action;
    logic        [IDX_W-1:0]   i_entry_index;
    logic        [TIME_W-1:0]  i_point_time;
    logic signed [STA_W-1:0]   i_lower_s;
    logic signed [STA_W-1:0]   i_upper_s;
    logic signed [STA_W-1:0]   i_query_s;
    logic                      o_done;
    logic                      o_inside_res;
    logic                      o_outside_time_window;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic        [COUNT_W-1:0] i_cfg_point_count;

    t_boundary_scoreboard sb;
    int items;
    int burst_left;
    int quiet;

    st_boundary_point_inside_test_top u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_start               (i_start),
        .o_busy                (o_busy),
        .i_action              (i_action),
        .i_entry_index         (i_entry_index),
        .i_point_time          (i_point_time),
        .i_lower_s             (i_lower_s),
        .i_upper_s             (i_upper_s),
        .i_query_s             (i_query_s),
        .o_done                (o_done),
        .o_inside_res          (o_inside_res),
        .o_outside_time_window (o_outside_time_window),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_point_count     (i_cfg_point_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [STA_W-1:0] clamp_sta(longint v);
        if (v > 64'sd8388607)
            return 24'sh7FFFFF;
        if (v < -64'sd8388608)
            return 24'sh800000;
        return v[STA_W-1:0];
    endfunction

    function automatic logic signed [STA_W-1:0] rand_sta();
        return STA_W'($urandom());
    endfunction

    function automatic t_cmd load_cmd(int idx, int t_ms, longint lo_s, longint up_s);
        t_cmd c;
        c.action = ACT_LOAD;
        c.idx    = IDX_W'(idx);
        c.t_ms   = TIME_W'(t_ms);
        c.lo_s   = clamp_sta(lo_s);
        c.up_s   = clamp_sta(up_s);
        c.q_s    = rand_sta();
        return c;
    endfunction

    function automatic t_cmd query_cmd(int t_ms, longint q_s);
        t_cmd c;
        c.action = ACT_QUERY;
        c.idx    = IDX_W'($urandom());
        c.t_ms   = TIME_W'(t_ms);
        c.lo_s   = rand_sta();
        c.up_s   = rand_sta();
        c.q_s    = clamp_sta(q_s);
        return c;
    endfunction

    task automatic issue(input t_cmd c);
        int gap;
        i_start       <= 1'b1;
        i_action      <= c.action;
        i_entry_index <= c.idx;
        i_point_time  <= c.t_ms;
        i_lower_s     <= c.lo_s;
        i_upper_s     <= c.up_s;
        i_query_s     <= c.q_s;
        do @(posedge i_clk); while (o_busy);
        sb.record_command(c);
        items++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (sb.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] v);
        i_cfg_valid       <= 1'b1;
        i_cfg_point_count <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_count(v);
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] raw);
        int     n, shape, nq, base, step_max, tq, j, t0, tl;
        longint lo_s, up_s, tmp, q_s;
        drain();
        write_count(raw);
        n     = sb.n_used;
        shape = $urandom_range(0, 9);
        base  = $urandom_range(0, 2000);
        step_max = (65535 - base) / (n - 1);
        if ($urandom_range(0, 2) == 0 && step_max > 4)
            step_max = 4;
        tq = base;
        for (int k = 0; k < n; k++) begin
            if (shape == 0) begin
                issue(load_cmd(k, $urandom_range(0, 65535), rand_sta(), rand_sta()));
            end else begin
                lo_s = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
                up_s = lo_s + $urandom_range(0, (1 << 22) - 1);
                if ($urandom_range(0, 9) == 0) begin
                    tmp  = lo_s;
                    lo_s = up_s;
                    up_s = tmp;
                end
                issue(load_cmd(k, tq, lo_s, up_s));
                tq += (shape == 1) ? $urandom_range(0, step_max) : $urandom_range(1, step_max);
                if (tq > 65535)
                    tq = 65535;
            end
        end
        nq = $urandom_range(15, 45);
        repeat (nq) begin
            t0 = sb.time_tab[0];
            tl = sb.time_tab[n-1];
            j  = $urandom_range(0, n - 1);
            case ($urandom_range(0, 19))
                0: begin
                    issue(load_cmd($urandom_range(0, 63), $urandom_range(0, 65535),
                                   rand_sta(), rand_sta()));
                end
                1, 2: begin
                    issue(query_cmd($urandom_range(0, 65535), rand_sta()));
                end
                3, 4: begin
                    q_s = ($urandom_range(0, 1)) ? sb.upper_tab[j] : sb.lower_tab[j];
                    issue(query_cmd(sb.time_tab[j], q_s));
                end
                5: begin
                    tq = ($urandom_range(0, 1)) ? $urandom_range(0, t0) : $urandom_range(tl, 65535);
                    issue(query_cmd(tq, sb.lower_tab[j]));
                end
                default: begin
                    if (tl > t0 + 1)
                        tq = $urandom_range(t0 + 1, tl - 1);
                    else
                        tq = $urandom_range(0, 65535);
                    case ($urandom_range(0, 5))
                        0: q_s = sb.lower_tab[j];
                        1: q_s = sb.upper_tab[j];
                        2: q_s = (longint'(sb.lower_tab[j]) + sb.upper_tab[j]) / 2;
                        3: q_s = longint'(sb.lower_tab[j]) + $urandom_range(0, 8) - 4;
                        4: q_s = longint'(sb.upper_tab[j]) + $urandom_range(0, 8) - 4;
                        default: q_s = longint'(sb.lower_tab[j]) +
                            (longint'(sb.upper_tab[j]) - sb.lower_tab[j]) *
                            longint'($urandom_range(0, 100)) / 100;
                    endcase
                    issue(query_cmd(tq, q_s));
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.compare_verdict(o_inside_res, o_outside_time_window);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        logic [COUNT_W-1:0] sweep [7];
        i_rst_n           <= 1'b0;
        i_start           <= 1'b0;
        i_action          <= ACT_LOAD;
        i_entry_index     <= '0;
        i_point_time      <= '0;
        i_lower_s         <= '0;
        i_upper_s         <= '0;
        i_query_s         <= '0;
        i_cfg_valid       <= 1'b0;
        i_cfg_point_count <= '0;
        sb         = new();
        items      = 0;
        burst_left = $urandom_range(1, 24);
        sweep      = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd2, 7'd65, 7'd3};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // two-entry table at reset count: full-scale, then narrow, crossed, non-rising
        issue(load_cmd(0, 0, -8388608, 8388607));
        issue(load_cmd(1, 65535, -8388608, 8388607));
        issue(query_cmd(0, 0));
        issue(query_cmd(65535, 0));
        issue(query_cmd(32768, 0));
        issue(query_cmd(1, -8388608));
        issue(query_cmd(40000, 8388607));
        issue(load_cmd(63, 65535, 0, 0));
        issue(load_cmd(0, 100, -1000, 1000));
        issue(load_cmd(1, 200, -1000, 1000));
        issue(query_cmd(50, 0));
        issue(query_cmd(250, 0));
        issue(query_cmd(150, 999));
        issue(query_cmd(150, 1000));
        issue(query_cmd(150, 1001));
        issue(query_cmd(150, -1000));
        issue(query_cmd(150, -1001));
        issue(load_cmd(1, 200, 1000, -1000));
        issue(query_cmd(150, 0));
        issue(query_cmd(120, 500));
        issue(load_cmd(0, 300, -1000, 1000));
        issue(query_cmd(250, 0));

        foreach (sweep[k])
            run_phase(sweep[k]);
        while (items < ITEM_GOAL) begin
            case ($urandom_range(0, 9))
                0:       run_phase(COUNT_W'($urandom_range(0, 127)));
                1, 2:    run_phase(COUNT_W'($urandom_range(9, 32)));
                default: run_phase(COUNT_W'($urandom_range(2, 8)));
            endcase
        end
        drain();

        if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
design/stbpi_pkg.sv
design/stbpi_ram.sv
design/stbpi_cross.sv
design/st_boundary_point_inside_test_top.sv
bench/tb.sv
